// ===== rtl/idb_pkg.sv =====
package idb_pkg;

	// Default sizing of the ring store.
	localparam int unsigned DEF_CAPACITY   = 64;
	localparam int unsigned DEF_WORD_WIDTH = 32;

	// Fixed widths of the word fields on the channels.
	localparam int unsigned MODE_W = 3;
	localparam int unsigned ITEM_W = 32;
	localparam int unsigned POS_W  = 6;
	localparam int unsigned OCC_W  = 7;
	localparam int unsigned STAT_W = 2;

	// Operation codes carried in the mode field.
	typedef enum logic [MODE_W-1:0] {
		OP_PUSH_FRONT = 3'd0,
		OP_PUSH_BACK  = 3'd1,
		OP_POP_FRONT  = 3'd2,
		OP_POP_BACK   = 3'd3,
		OP_PEEK_FRONT = 3'd4,
		OP_PEEK_BACK  = 3'd5,
		OP_READ_AT    = 3'd6,
		OP_WRITE_AT   = 3'd7
	} op_t;

	// Completion codes carried in the status field.
	typedef enum logic [STAT_W-1:0] {
		ST_OK    = 2'd0,
		ST_FULL  = 2'd1,
		ST_EMPTY = 2'd2
	} status_t;

endpackage

// ===== rtl/idb_if.sv =====
// Request channel: one operation word per handshake.
interface idb_req_if;
	logic                                valid;
	logic                                ready;
	idb_pkg::op_t                        mode;
	logic [idb_pkg::ITEM_W-1:0]          item;
	logic [idb_pkg::POS_W-1:0]           position;

	modport source (output valid, output mode, output item, output position, input ready);
	modport sink   (input valid, input mode, input item, input position, output ready);
endinterface

// Response channel: one result word per handshake.
interface idb_rsp_if;
	logic                                valid;
	logic                                ready;
	logic [idb_pkg::ITEM_W-1:0]          data_out;
	logic [idb_pkg::OCC_W-1:0]           occupancy;
	idb_pkg::status_t                    status;

	modport source (output valid, output data_out, output occupancy, output status, input ready);
	modport sink   (input valid, input data_out, input occupancy, input status, output ready);
endinterface

// ===== rtl/indexed_deque_buffer_core.sv =====
// Bounded double-ended queue of data words with random access by offset from the front.
// Each request word performs one operation (push or pop at either end, peek at either
// end, indexed read or indexed write) and produces exactly one response word with the
// data, the occupancy after the operation and a status. Words live in a ring memory
// with a synchronous read; the front pointer and the count are registers and
// are updated at acceptance, so every operation makes at most one memory access. A
// response appears in the cycle after its request is accepted, and a new request is
// accepted every cycle as long as the response register is empty or being drained,
// so the sustained rate is one operation per clock. The ring store needs no clearing
// after reset, since only occupied entries can be read.
module indexed_deque_buffer_core #(
	parameter int unsigned CAPACITY   = idb_pkg::DEF_CAPACITY,
	parameter int unsigned WORD_WIDTH = idb_pkg::DEF_WORD_WIDTH
) (
	input  logic           clk,
	input  logic           arst_n,
	idb_req_if.sink        req,
	idb_rsp_if.source      rsp
);

	localparam int unsigned PTR_W  = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int unsigned CNT_W  = $clog2(CAPACITY + 1);
	localparam int unsigned SUM_W  = CNT_W + 1;
	localparam int unsigned CMP_W  = (CNT_W > idb_pkg::POS_W) ? CNT_W : idb_pkg::POS_W;
	localparam int unsigned KEEP_W = (WORD_WIDTH < idb_pkg::ITEM_W) ? WORD_WIDTH
	                                                                : idb_pkg::ITEM_W;

	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(CAPACITY);
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(CAPACITY - 1);
	localparam logic [SUM_W-1:0] SUM_CAP  = SUM_W'(CAPACITY);

	logic [PTR_W-1:0]            front_q;
	logic [CNT_W-1:0]            count_q;

	logic                        valid_s1;
	logic                        rd_sel_s1;
	logic [CNT_W-1:0]            count_s1;
	idb_pkg::status_t            status_s1;
	logic [KEEP_W-1:0]           rd_data_s1;

	logic [KEEP_W-1:0]           ring_mem [CAPACITY];

	logic                        accept;
	logic                        is_full;
	logic                        is_empty;
	logic                        idx_ok;
	logic [CNT_W-1:0]            offset;
	logic [SUM_W-1:0]            slot_sum;
	logic [PTR_W-1:0]            slot;
	logic [PTR_W-1:0]            front_dec;
	logic [PTR_W-1:0]            front_inc;

	logic [PTR_W-1:0]            front_d;
	logic [CNT_W-1:0]            count_d;
	logic [PTR_W-1:0]            mem_addr;
	logic                        mem_we;
	logic                        mem_re;
	idb_pkg::status_t            status_d;

	// The response register parts the two sides; it refills while being drained.
	assign accept    = req.valid && req.ready;
	assign req.ready = !valid_s1 || rsp.ready;

	assign is_full   = (count_q == CNT_FULL);
	assign is_empty  = (count_q == '0);
	assign idx_ok    = (CMP_W'(req.position) < CMP_W'(count_q));

	// Neighbors of the front pointer around the ring.
	assign front_dec = (front_q == '0) ? PTR_LAST : front_q - PTR_W'(1);
	assign front_inc = (front_q == PTR_LAST) ? '0 : front_q + PTR_W'(1);

	// Offset from the front that the operation touches.
	always_comb begin
		unique case (req.mode) inside
			idb_pkg::OP_PUSH_BACK:                         offset = count_q;
			idb_pkg::OP_POP_BACK, idb_pkg::OP_PEEK_BACK:   offset = count_q - CNT_W'(1);
			idb_pkg::OP_READ_AT, idb_pkg::OP_WRITE_AT:     offset = CNT_W'(req.position);
			default:                                       offset = '0;
		endcase
	end

	// Ring slot of that offset; for every access that is made, the sum stays below twice the capacity.
	always_comb begin
		slot_sum = SUM_W'(front_q) + SUM_W'(offset);
		if (slot_sum >= SUM_CAP) begin
			slot_sum = slot_sum - SUM_CAP;
		end
		slot = slot_sum[PTR_W-1:0];
	end

	// Operation decode: next pointer and count, memory access and status.
	always_comb begin
		front_d  = front_q;
		count_d  = count_q;
		mem_addr = slot;
		mem_we   = 1'b0;
		mem_re   = 1'b0;
		status_d = idb_pkg::ST_OK;
		unique case (req.mode) inside
			idb_pkg::OP_PUSH_FRONT: begin
				mem_addr = front_dec;
				if (is_full) begin
					status_d = idb_pkg::ST_FULL;
				end else begin
					front_d = front_dec;
					count_d = count_q + CNT_W'(1);
					mem_we  = 1'b1;
				end
			end
			idb_pkg::OP_PUSH_BACK: begin
				if (is_full) begin
					status_d = idb_pkg::ST_FULL;
				end else begin
					count_d = count_q + CNT_W'(1);
					mem_we  = 1'b1;
				end
			end
			idb_pkg::OP_POP_FRONT, idb_pkg::OP_PEEK_FRONT: begin
				mem_addr = front_q;
				if (is_empty) begin
					status_d = idb_pkg::ST_EMPTY;
				end else begin
					mem_re = 1'b1;
					if (req.mode == idb_pkg::OP_POP_FRONT) begin
						front_d = front_inc;
						count_d = count_q - CNT_W'(1);
					end
				end
			end
			idb_pkg::OP_POP_BACK, idb_pkg::OP_PEEK_BACK: begin
				if (is_empty) begin
					status_d = idb_pkg::ST_EMPTY;
				end else begin
					mem_re = 1'b1;
					if (req.mode == idb_pkg::OP_POP_BACK) begin
						count_d = count_q - CNT_W'(1);
					end
				end
			end
			idb_pkg::OP_READ_AT: begin
				if (!idx_ok) begin
					status_d = idb_pkg::ST_EMPTY;
				end else begin
					mem_re = 1'b1;
				end
			end
			idb_pkg::OP_WRITE_AT: begin
				if (!idx_ok) begin
					status_d = idb_pkg::ST_EMPTY;
				end else begin
					mem_we = 1'b1;
				end
			end
			default: begin
				status_d = idb_pkg::ST_OK;
			end
		endcase
	end

	// Ring memory: at most one access per accepted word, read data registered.
	always_ff @(posedge clk) begin
		if (accept && mem_we) begin
			ring_mem[mem_addr] <= req.item[KEEP_W-1:0];
		end
		if (accept && mem_re) begin
			rd_data_s1 <= ring_mem[mem_addr];
		end
	end

	// Pointer and count registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			front_q <= '0;
			count_q <= '0;
		end else if (accept) begin
			front_q <= front_d;
			count_q <= count_d;
		end
	end

	// Response register control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req.ready) begin
			valid_s1 <= req.valid;
		end
	end

	// Response register payload.
	always_ff @(posedge clk) begin
		if (accept) begin
			rd_sel_s1 <= mem_re;
			count_s1  <= count_d;
			status_s1 <= status_d;
		end
	end

	assign rsp.valid     = valid_s1;
	assign rsp.data_out  = rd_sel_s1 ? idb_pkg::ITEM_W'(rd_data_s1) : '0;
	assign rsp.occupancy = idb_pkg::OCC_W'(count_s1);
	assign rsp.status    = status_s1;

endmodule
